// File: hw/rtl/spavdec_pkg.sv
// Shared constants and types for the spectrum average and decimation block.
// Used by spavdec_decim and spectrum_average_decimate_top; depends on nothing.
`default_nettype none

package spavdec_pkg;

	localparam int MAG_W     = 16;
	localparam int BIN_W     = 17;
	localparam int POS_W     = 16;
	localparam int MAX_BINS  = 65536;
	localparam int OUT_BINS  = 2048;
	localparam int OUT_SHIFT = 11;
	localparam int GRP_W     = 6;
	localparam int ALPHA_W   = 17;
	localparam int ALPHA_ONE = 65536;
	localparam int FRAME_RST = 2048;
	localparam int Q_DEPTH   = 4;
	localparam int Q_PTR_W   = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ALPHA      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DC_ENABLE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_BINS = 2'd2;

	typedef struct packed {
		logic                    valid;
		logic signed [MAG_W-1:0] value;
		logic                    has_prev;
		logic                    centre;
		logic                    last;
	} dec_item_t;

	typedef struct packed {
		logic signed [MAG_W-1:0] value;
		logic [POS_W-1:0]        index;
		logic                    last;
	} dec_result_t;

endpackage

`default_nettype wire

// File: hw/rtl/spavdec_decim.sv
// Centre-bin repair, max decimation and the output queue.
// Depends on spavdec_pkg; instantiated by spectrum_average_decimate_top.
`default_nettype none

module spavdec_decim (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  logic [spavdec_pkg::BIN_W-1:0]        n_bins,
	input  spavdec_pkg::dec_item_t               item,
	output logic                                 room,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [spavdec_pkg::MAG_W-1:0] spectrum_value,
	output logic [spavdec_pkg::POS_W-1:0]        out_index,
	output logic                                 frame_last
);

	logic signed [spavdec_pkg::MAG_W-1:0] prev_q, bpp_q, gm_q;
	logic [spavdec_pkg::GRP_W-1:0]        gf_q;
	logic [spavdec_pkg::POS_W-1:0]        op_q;

	logic                                 big;
	logic [spavdec_pkg::GRP_W-1:0]        quot, size_a;
	logic [spavdec_pkg::OUT_SHIFT-1:0]    rem;
	logic signed [spavdec_pkg::MAG_W:0]   mean_sum;
	logic signed [spavdec_pkg::MAG_W-1:0] v1, x, gm_a, gm_b, gm_n;
	logic [spavdec_pkg::GRP_W-1:0]        gf_a, gf_n;
	logic [spavdec_pkg::POS_W-1:0]        op_a, op_n;
	logic                                 e1, e2;
	spavdec_pkg::dec_result_t             r1, r2, ent_a;

	spavdec_pkg::dec_result_t             q_mem [spavdec_pkg::Q_DEPTH];
	logic [spavdec_pkg::Q_PTR_W-1:0]      rp_q, wp_q, wp_b;
	logic [spavdec_pkg::Q_PTR_W:0]        cnt_q;
	logic [1:0]                           n_push;
	logic                                 step, wr_a, wr_b, pop;

	assign x        = item.value;
	assign big      = n_bins > spavdec_pkg::BIN_W'(spavdec_pkg::OUT_BINS);
	assign quot     = spavdec_pkg::GRP_W'(n_bins >> spavdec_pkg::OUT_SHIFT);
	assign rem      = n_bins[spavdec_pkg::OUT_SHIFT-1:0];
	assign mean_sum = $signed({bpp_q[spavdec_pkg::MAG_W-1], bpp_q})
		+ $signed({x[spavdec_pkg::MAG_W-1], x});
	assign v1       = item.centre ? mean_sum[spavdec_pkg::MAG_W:1] : prev_q;
	assign size_a   = quot + spavdec_pkg::GRP_W'(op_q <
		spavdec_pkg::POS_W'(rem));

	always_comb begin
		gm_a = gm_q;
		gf_a = gf_q;
		op_a = op_q;
		e1   = 1'b0;
		if (item.has_prev) begin
			if (!big) begin
				e1   = 1'b1;
				op_a = op_q + 1'b1;
				gf_a = '0;
			end else begin
				if (gf_q == '0 || $signed(v1) > $signed(gm_q)) begin
					gm_a = v1;
				end
				gf_a = gf_q + 1'b1;
				if (gf_a >= size_a) begin
					e1   = 1'b1;
					op_a = op_q + 1'b1;
					gf_a = '0;
				end
			end
		end
		r1.value = big ? gm_a : v1;
		r1.index = op_q;
		r1.last  = 1'b0;

		gm_b = (gf_a == '0 || $signed(x) > $signed(gm_a)) ? x : gm_a;
		gm_n = gm_a;
		gf_n = gf_a;
		op_n = op_a;
		e2   = 1'b0;
		if (item.last) begin
			e2   = 1'b1;
			op_n = '0;
			gf_n = '0;
			if (big) begin
				gm_n = gm_b;
			end
		end
		r2.value = big ? gm_b : x;
		r2.index = op_a;
		r2.last  = 1'b1;
	end

	assign step   = adv & item.valid;
	assign wr_a   = step & (e1 | e2);
	assign wr_b   = step & e1 & e2;
	assign ent_a  = e1 ? r1 : r2;
	assign wp_b   = wp_q + spavdec_pkg::Q_PTR_W'(1);
	assign n_push = {1'b0, wr_a} + {1'b0, wr_b};
	assign pop    = out_valid & out_ready;
	assign room   = cnt_q <= (spavdec_pkg::Q_PTR_W + 1)'(spavdec_pkg::Q_DEPTH - 2);

	assign out_valid      = cnt_q != '0;
	assign spectrum_value = q_mem[rp_q].value;
	assign out_index      = q_mem[rp_q].index;
	assign frame_last     = q_mem[rp_q].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			bpp_q  <= '0;
			gm_q   <= '0;
			gf_q   <= '0;
			op_q   <= '0;
			rp_q   <= '0;
			wp_q   <= '0;
			cnt_q  <= '0;
		end else begin
			if (step) begin
				prev_q <= x;
				bpp_q  <= prev_q;
				gm_q   <= gm_n;
				gf_q   <= gf_n;
				op_q   <= op_n;
			end
			if (pop) begin
				rp_q <= rp_q + spavdec_pkg::Q_PTR_W'(1);
			end
			wp_q  <= wp_q + spavdec_pkg::Q_PTR_W'(n_push);
			cnt_q <= cnt_q + (spavdec_pkg::Q_PTR_W + 1)'(n_push)
				- (spavdec_pkg::Q_PTR_W + 1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_a) begin
			q_mem[wp_q] <= ent_a;
		end
		if (wr_b) begin
			q_mem[wp_b] <= r2;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/spectrum_average_decimate_top.sv
// Top level: configuration registers, the per-bin average memory and its
// read-modify-write pipeline. Depends on spavdec_pkg and spavdec_decim.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    magnitude
//   out      source     out_valid / out_ready  spectrum_value, out_index, frame_last
//   cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One bin is taken per cycle while input is not held off and no bubble is inserted;
// results pass through stages s1, s2 and s3 into a four-item queue. A bubble
// is inserted when two consecutive bins hit the same average entry (one-bin
// frames with averaging on), as the memory read is registered. Input is held off while the queue holds three or
// more items. Reset clears control state only; the average memory needs no
// clearing pass, as an entry is read only after its frame has loaded it.
`default_nettype none

module spectrum_average_decimate_top (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic signed [spavdec_pkg::MAG_W-1:0]     magnitude,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic signed [spavdec_pkg::MAG_W-1:0]     spectrum_value,
	output logic [spavdec_pkg::POS_W-1:0]            out_index,
	output logic                                     frame_last,
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [spavdec_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [spavdec_pkg::ALPHA_W-1:0]          cfg_data
);

	logic [spavdec_pkg::ALPHA_W-1:0]      alpha_q;
	logic                                 dc_q;
	logic [spavdec_pkg::BIN_W-1:0]        frame_q, avg_size_q, n_eff;
	logic [spavdec_pkg::POS_W-1:0]        pos_q;

	logic                                 adv, hazard, acc, last0, centre0, wr0;

	logic signed [spavdec_pkg::MAG_W-1:0] avg_mem [spavdec_pkg::MAX_BINS];

	logic                                 valid_s1, wr_s1, blend_s1, prev_s1, centre_s1, last_s1;
	logic signed [spavdec_pkg::MAG_W-1:0] x_s1, rdata_s1;
	logic [spavdec_pkg::POS_W-1:0]        idx_s1;

	logic                                 valid_s2, wr_s2, blend_s2, prev_s2, centre_s2, last_s2;
	logic signed [spavdec_pkg::MAG_W-1:0] x_s2;
	logic [spavdec_pkg::POS_W-1:0]        idx_s2;
	logic signed [34:0]                   prod_s2;

	logic                                 valid_s3, wr_s3, prev_s3, centre_s3, last_s3;
	logic signed [spavdec_pkg::MAG_W-1:0] fin_s3;
	logic [spavdec_pkg::POS_W-1:0]        idx_s3;

	logic signed [spavdec_pkg::MAG_W-1:0] avg_sel, bl_sat, fin_s2;
	logic signed [spavdec_pkg::MAG_W:0]   diff;
	logic signed [34:0]                   prod;
	logic signed [35:0]                   bl_sum;
	logic signed [19:0]                   bl_round;

	spavdec_pkg::dec_item_t               item_s3;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= '0;
			dc_q    <= 1'b0;
			frame_q <= spavdec_pkg::BIN_W'(spavdec_pkg::FRAME_RST);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				spavdec_pkg::REG_ALPHA: begin
					alpha_q <= (cfg_data > spavdec_pkg::ALPHA_W'(spavdec_pkg::ALPHA_ONE))
						? spavdec_pkg::ALPHA_W'(spavdec_pkg::ALPHA_ONE) : cfg_data;
				end
				spavdec_pkg::REG_DC_ENABLE: begin
					dc_q <= cfg_data[0];
				end
				spavdec_pkg::REG_FRAME_BINS: begin
					frame_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (frame_q == '0) begin
			n_eff = spavdec_pkg::BIN_W'(1);
		end else if (frame_q > spavdec_pkg::BIN_W'(spavdec_pkg::MAX_BINS)) begin
			n_eff = spavdec_pkg::BIN_W'(spavdec_pkg::MAX_BINS);
		end else begin
			n_eff = frame_q;
		end
	end

	assign hazard   = valid_s1 && wr_s1 && (idx_s1 == pos_q);
	assign in_ready = adv && !hazard;
	assign acc      = in_valid && in_ready;
	assign wr0      = alpha_q != '0;
	assign last0    = ({1'b0, pos_q} + spavdec_pkg::BIN_W'(1)) >= n_eff;
	assign centre0  = dc_q && (n_eff > spavdec_pkg::BIN_W'(2)) && (pos_q != '0)
		&& (({1'b0, pos_q} - spavdec_pkg::BIN_W'(1)) == (n_eff >> 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			avg_size_q <= '0;
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			valid_s3   <= 1'b0;
		end else begin
			if (acc) begin
				pos_q <= last0 ? '0 : pos_q + 1'b1;
				if (wr0 && last0) begin
					avg_size_q <= n_eff;
				end
			end
			if (adv) begin
				valid_s1 <= acc;
				valid_s2 <= valid_s1;
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rdata_s1 <= avg_mem[pos_q];
		end
		if (adv && valid_s2 && wr_s2) begin
			avg_mem[idx_s2] <= fin_s2;
		end
	end

	assign avg_sel = (valid_s3 && wr_s3 && (idx_s3 == idx_s1)) ? fin_s3 : rdata_s1;
	assign diff    = $signed({avg_sel[spavdec_pkg::MAG_W-1], avg_sel})
		- $signed({x_s1[spavdec_pkg::MAG_W-1], x_s1});
	assign prod    = $signed({1'b0, alpha_q}) * diff;

	assign bl_sum   = $signed({{4{x_s2[spavdec_pkg::MAG_W-1]}}, x_s2, 16'h0000})
		+ 36'(prod_s2) + 36'sd32768;
	assign bl_round = bl_sum[35:16];

	always_comb begin
		if (bl_round > 20'sd32767) begin
			bl_sat = 16'sh7FFF;
		end else if (bl_round < -20'sd32768) begin
			bl_sat = 16'sh8000;
		end else begin
			bl_sat = bl_round[spavdec_pkg::MAG_W-1:0];
		end
	end

	assign fin_s2 = blend_s2 ? bl_sat : x_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (acc) begin
				x_s1      <= magnitude;
				idx_s1    <= pos_q;
				wr_s1     <= wr0;
				blend_s1  <= wr0 && (avg_size_q == n_eff);
				prev_s1   <= pos_q != '0;
				centre_s1 <= centre0;
				last_s1   <= last0;
			end
			x_s2      <= x_s1;
			idx_s2    <= idx_s1;
			wr_s2     <= wr_s1;
			blend_s2  <= blend_s1;
			prev_s2   <= prev_s1;
			centre_s2 <= centre_s1;
			last_s2   <= last_s1;
			prod_s2   <= prod;
			fin_s3    <= fin_s2;
			idx_s3    <= idx_s2;
			wr_s3     <= wr_s2;
			prev_s3   <= prev_s2;
			centre_s3 <= centre_s2;
			last_s3   <= last_s2;
		end
	end

	assign item_s3.valid    = valid_s3;
	assign item_s3.value    = fin_s3;
	assign item_s3.has_prev = prev_s3;
	assign item_s3.centre   = centre_s3;
	assign item_s3.last     = last_s3;

	spavdec_decim u_decim (
		.clk            (clk),
		.arst_n         (arst_n),
		.adv            (adv),
		.n_bins         (n_eff),
		.item           (item_s3),
		.room           (adv),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.spectrum_value (spectrum_value),
		.out_index      (out_index),
		.frame_last     (frame_last)
	);

`ifndef SYNTHESIS
	a_no_same_entry_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && wr_s1 && wr_s2) |-> (idx_s1 != idx_s2))
		else $error("two bins in flight update the same average entry");

	a_accept_loads_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$past(acc && arst_n) |-> (valid_s1 && (idx_s1 == $past(pos_q))))
		else $error("accepted bin did not enter the first stage");

	a_centre_has_prev: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && centre_s1) |-> prev_s1)
		else $error("centre repair marked on the first bin of a frame");
`endif

endmodule

`default_nettype wire

// File: verif/spectrum_average_decimate_top_test.sv
// Self-checking testbench for spectrum_average_decimate_top: averaging, centre-bin repair
// and max decimation, checked item by item against a predictor of its own.
// Depends on spavdec_pkg and the block's RTL only.
`timescale 1ns / 100ps

module spectrum_average_decimate_top_test;

	import spavdec_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
	localparam logic [3:0] SET_ALPHA = 4'b0001;
	localparam logic [3:0] SET_DC    = 4'b0010;
	localparam logic [3:0] SET_FRAME = 4'b0100;
	localparam logic [3:0] SET_NONE  = 4'b1000;
	localparam logic [3:0] SET_ALL   = 4'b1111;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int RANDOM_BINS = 1500;

	class spectrum_ledger;
		logic signed [MAG_W-1:0] avg_mem [MAX_BINS];
		int unsigned alpha_w;
		int unsigned frame_cfg;
		int unsigned avg_size;
		int unsigned bin_pos;
		int unsigned grp_fill;
		int unsigned out_pos;
		bit dc_on;
		logic signed [MAG_W-1:0] prev_bin;
		logic signed [MAG_W-1:0] prev2_bin;
		logic signed [MAG_W-1:0] grp_max;
		dec_result_t expected_bins[$];
		int mismatches;

		function new();
			alpha_w = 0;
			frame_cfg = FRAME_RST;
			avg_size = 0;
			bin_pos = 0;
			grp_fill = 0;
			out_pos = 0;
			dc_on = 1'b0;
			prev_bin = '0;
			prev2_bin = '0;
			grp_max = '0;
			mismatches = 0;
		endfunction

		function int unsigned frame_size();
			if (frame_cfg == 0) return 1;
			if (frame_cfg > MAX_BINS) return MAX_BINS;
			return frame_cfg;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [ALPHA_W-1:0] data);
			case (idx)
			REG_ALPHA: alpha_w = (data > ALPHA_ONE) ? ALPHA_ONE : data;
			REG_DC_ENABLE: dc_on = data[0];
			REG_FRAME_BINS: frame_cfg = data;
			default: ;
			endcase
		endfunction

		function logic signed [MAG_W-1:0] blend(logic signed [MAG_W-1:0] held,
			logic signed [MAG_W-1:0] sample);
			longint s;
			s = longint'(alpha_w) * held + longint'(ALPHA_ONE - alpha_w) * sample;
			s = (s + 32768) >>> 16;
			if (s > 32767) s = 32767;
			if (s < -32768) s = -32768;
			return s[MAG_W-1:0];
		endfunction

		function void emit(logic signed [MAG_W-1:0] v, bit last);
			dec_result_t r;
			r.value = v;
			r.index = out_pos[POS_W-1:0];
			r.last = last;
			expected_bins.push_back(r);
			out_pos = last ? 0 : out_pos + 1;
			grp_fill = 0;
		endfunction

		// Frames above OUT_BINS collapse into group maxima; a short frame end flushes the group.
		function void push(logic signed [MAG_W-1:0] v, bit last, int unsigned n);
			int unsigned span;
			if (n <= OUT_BINS) begin
				emit(v, last);
				return;
			end
			if (grp_fill == 0 || v > grp_max) grp_max = v;
			grp_fill++;
			span = n / OUT_BINS;
			if (out_pos < n % OUT_BINS) span++;
			if (grp_fill >= span || last) emit(grp_max, last);
		endfunction

		function void note_bin(logic signed [MAG_W-1:0] mag);
			int unsigned n;
			int unsigned pos;
			bit last;
			logic signed [MAG_W-1:0] x;
			logic signed [MAG_W-1:0] v;
			int mean;
			n = frame_size();
			pos = bin_pos;
			last = (pos + 1 >= n);
			x = mag;
			if (alpha_w != 0) begin
				if (avg_size != n) begin
					avg_mem[pos] = x;
				end else begin
					x = blend(avg_mem[pos], x);
					avg_mem[pos] = x;
				end
				if (last) avg_size = n;
			end
			if (pos > 0) begin
				v = prev_bin;
				if (dc_on && n > 2 && pos - 1 == n / 2) begin
					mean = (int'(prev2_bin) + int'(x)) >>> 1;
					v = mean[MAG_W-1:0];
				end
				push(v, 1'b0, n);
			end
			if (last) begin
				push(x, 1'b1, n);
				bin_pos = 0;
			end else begin
				bin_pos = pos + 1;
			end
			prev2_bin = prev_bin;
			prev_bin = x;
		endfunction

		function void check_output(logic signed [MAG_W-1:0] value, logic [POS_W-1:0] index,
			logic last);
			dec_result_t want;
			if (expected_bins.size() == 0) begin
				mismatches++;
				$error("unexpected output: spectrum_value %0d, out_index %0d, frame_last %0b",
					value, index, last);
				return;
			end
			want = expected_bins.pop_front();
			if (value !== want.value) begin
				mismatches++;
				$error("spectrum_value: expected %0d, actual %0d", want.value, value);
			end
			if (index !== want.index) begin
				mismatches++;
				$error("out_index: expected %0d, actual %0d", want.index, index);
			end
			if (last !== want.last) begin
				mismatches++;
				$error("frame_last: expected %0b, actual %0b", want.last, last);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [MAG_W-1:0] magnitude;
	logic out_valid;
	logic out_ready;
	logic signed [MAG_W-1:0] spectrum_value;
	logic [POS_W-1:0] out_index;
	logic frame_last;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ALPHA_W-1:0] cfg_data;

	spectrum_ledger ledger = new();
	bit squeeze;
	bit in_calm;
	int random_bins;

	spectrum_average_decimate_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.magnitude      (magnitude),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.spectrum_value (spectrum_value),
		.out_index      (out_index),
		.frame_last     (frame_last),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #4 clk = ~clk;

	task automatic send_bin(logic signed [MAG_W-1:0] mag);
		int gap;
		gap = in_calm ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		magnitude <= mag;
		do @(posedge clk); while (!in_ready);
		ledger.note_bin(mag);
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (ledger.expected_bins.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ALPHA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		ledger.write_register(idx, data);
		@(negedge clk);
	endtask

	task automatic configure(logic [3:0] mask, logic [ALPHA_W-1:0] a, logic dc,
		logic [ALPHA_W-1:0] fb);
		settle();
		if (mask[REG_ALPHA]) write_reg(REG_ALPHA, a);
		if (mask[REG_DC_ENABLE]) write_reg(REG_DC_ENABLE, ALPHA_W'(dc));
		if (mask[REG_FRAME_BINS]) write_reg(REG_FRAME_BINS, fb);
		if (mask[REG_NONE]) write_reg(REG_NONE, ALPHA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [MAG_W-1:0] pick_magnitude();
		case ($urandom_range(0, 9))
		0: return -32768;
		1: return 32767;
		2: return MAG_W'(int'($urandom_range(0, 255)) - 128);
		default: return MAG_W'($urandom);
		endcase
	endfunction

	function automatic logic [ALPHA_W-1:0] pick_alpha();
		case ($urandom_range(0, 5))
		0: return 0;
		1: return ALPHA_ONE;
		2: return $urandom_range(ALPHA_ONE + 1, 2 * ALPHA_ONE - 1);
		3: return $urandom_range(1, 16);
		default: return $urandom_range(1, ALPHA_ONE - 1);
		endcase
	endfunction

	// Mostly short frames; long ones are only ever sent in part and cut short later.
	function automatic logic [ALPHA_W-1:0] pick_frame_bins();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return $urandom_range(0, 24);
		if (r < 62) return $urandom_range(25, 200);
		if (r < 70) return $urandom_range(1, 3);
		if (r < 82) return OUT_BINS * $urandom_range(1, 31) + $urandom_range(1, 24);
		if (r < 88) return MAX_BINS;
		if (r < 94) return $urandom_range(MAX_BINS + 1, 2 * MAX_BINS - 1);
		return $urandom_range(OUT_BINS + 1, MAX_BINS - 1);
	endfunction

	initial begin : receiver
		int gap;
		bit calm;
		calm = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 63) == 0) calm = !calm;
			gap = calm ? 0 : $urandom_range(0, 9);
			if (squeeze) begin
				squeeze = 1'b0;
				gap = HOLD_OFF_CYCLES;
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			ledger.check_output(spectrum_value, out_index, frame_last);
			@(negedge clk);
		end
	end

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		int unsigned n;
		int unsigned rem;
		int count;
		logic [3:0] mask;
		logic [ALPHA_W-1:0] a;
		arst_n = 1'b0;
		in_valid = 1'b0;
		magnitude = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_ALPHA;
		cfg_data = '0;
		squeeze = 1'b0;
		in_calm = 1'b0;
		random_bins = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// One-bin frames at the magnitude extremes, averaging off.
		configure(SET_ALL, '0, 1'b0, '0);
		send_bin(-32768);
		send_bin(32767);
		// Centre bin of a five-bin frame replaced by its neighbours' mean.
		configure(SET_DC | SET_FRAME, '0, 1'b1, 5);
		send_bin(0);
		send_bin(-1);
		send_bin(1);
		send_bin(32767);
		send_bin(-32768);
		// Alpha above one acts as one: the first frame loads, the second keeps the store.
		configure(SET_ALPHA | SET_DC | SET_FRAME, 2 * ALPHA_ONE - 1, 1'b0, 4);
		repeat (8) send_bin(pick_magnitude());
		// Back-to-back one-bin frames hitting the same average entry.
		configure(SET_ALPHA | SET_FRAME, 1, 1'b0, 1);
		repeat (3) send_bin(pick_magnitude());
		// Oversized frame cut short by shrinking the frame size mid-frame.
		configure(SET_ALPHA | SET_FRAME, ALPHA_ONE / 2, 1'b0, 2 * MAX_BINS - 1);
		repeat (3) send_bin(pick_magnitude());
		configure(SET_FRAME, '0, 1'b0, 2);
		send_bin(pick_magnitude());

		// Receiver holds off while the sender keeps offering items.
		configure(SET_ALPHA | SET_DC | SET_FRAME, 40000, 1'b1, 8);
		in_calm = 1'b1;
		squeeze = 1'b1;
		repeat (160) begin
			send_bin(pick_magnitude());
			random_bins++;
		end

		while (random_bins < RANDOM_BINS) begin
			in_calm = ($urandom_range(0, 3) == 0);
			a = pick_alpha();
			// Averaging may not start partway through a frame.
			if (ledger.bin_pos != 0 && ledger.alpha_w == 0) a = '0;
			mask = SET_FRAME;
			if ($urandom_range(0, 1)) mask |= SET_ALPHA;
			if ($urandom_range(0, 3) == 0) mask |= SET_DC;
			configure(mask, a, 1'($urandom_range(0, 1)), pick_frame_bins());
			n = ledger.frame_size();
			rem = (n > ledger.bin_pos) ? n - ledger.bin_pos : 1;
			if (n > OUT_BINS) count = $urandom_range(1, 150);
			else if ($urandom_range(0, 6) == 0) count = $urandom_range(1, 2 * n);
			else count = rem + n * $urandom_range(0, (n > 40) ? 1 : 3);
			repeat (count) begin
				send_bin(pick_magnitude());
				random_bins++;
			end
		end

		settle();
		if (ledger.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
